// File: design/stb_pkg.sv
// Package for the software timer bank: widths, action codes and beat types.
// No dependencies; every file of the timer bank imports it.
`default_nettype none

package stb_pkg;

  localparam int unsigned NumTimersDef = 8;
  localparam int unsigned TimerW       = 32;
  localparam int unsigned IndexW       = 5;
  localparam int unsigned ActionW      = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_QUERY  = 3'd5
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  timer_index;
    logic [TimerW-1:0]  duration_ticks;
  } stb_in_t;

  typedef struct packed {
    logic [IndexW-1:0] queried_index;
    logic              expired;
    logic              running;
  } stb_out_t;

endpackage

`default_nettype wire

// File: design/software_timer_bank_unit.sv
// Software timer bank top level: counter RAM, one shared incrementer and a small sequencer.
// Depends on stb_pkg for widths, action codes and the beat types.
//
// The bank holds NUM_TIMERS 32-bit counters in a single-port RAM with one valid bit per
// entry, so all counters read as zero after reset without a clearing pass. Each input beat
// is handled by a three-state sequencer that reads one counter, runs it through the shared
// adder and writes it back. A tick sweeps every counter, reading and writing each entry in
// turn; start, stop, pause and resume read and write one entry, a query only reads one, and
// unused action codes go back to idle without a RAM access. A query result sits in an
// output register, so the next beat is accepted while it waits; only a second query stalls
// until the first result has been taken.
`default_nettype none

module software_timer_bank_unit
  import stb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire stb_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output stb_out_t      out_data_o
);

  localparam int unsigned AddrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [ActionW-1:0]  act_q, act_d;
  logic [IndexW-1:0]   idx_q, idx_d;
  logic [TimerW-1:0]   dur_q, dur_d;
  logic                in_range_q, in_range_d;
  logic [AddrW-1:0]    sweep_q, sweep_d;
  logic                out_valid_q, out_valid_d;
  stb_out_t            out_data_q, out_data_d;

  logic [TimerW-1:0]   mem_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_q;
  logic [TimerW-1:0]   rdata_q;
  logic                rd_vld_q;

  logic [AddrW-1:0]    raddr;
  logic                re;
  logic [AddrW-1:0]    waddr;
  logic                we;
  logic [TimerW-1:0]   wdata;
  logic [TimerW-1:0]   rd_cnt;
  logic [TimerW-1:0]   add_a;
  logic                add_c;
  logic [TimerW-1:0]   add_sum;
  logic                is_tick;
  logic                is_query;
  logic                exec_go;
  logic                sweep_last;
  logic                accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign is_tick    = (act_q == ACT_TICK);
  assign is_query   = (act_q == ACT_QUERY);
  assign sweep_last = (sweep_q == AddrW'(NUM_TIMERS - 1));
  assign exec_go    = !is_query || !out_valid_q || out_ready_i;

  assign rd_cnt  = (rd_vld_q && (in_range_q || is_tick)) ? rdata_q : '0;
  assign add_a   = (act_q == ACT_START) ? ~dur_q : rd_cnt;
  assign add_c   = (act_q == ACT_START) || (is_tick && rd_cnt[TimerW-1]);
  assign add_sum = add_a + TimerW'(add_c);

  assign raddr = is_tick ? sweep_q : (in_range_q ? idx_q[AddrW-1:0] : '0);
  assign re    = (state_q == ST_READ);
  assign waddr = raddr;

  always_comb begin
    wdata = rd_cnt;
    we    = 1'b0;
    case (action_e'(act_q))
      ACT_TICK: begin
        wdata = add_sum;
        we    = 1'b1;
      end
      ACT_START: begin
        wdata = add_sum;
        we    = in_range_q;
      end
      ACT_STOP: begin
        wdata = '0;
        we    = in_range_q;
      end
      ACT_PAUSE: begin
        wdata = {1'b0, rd_cnt[TimerW-2:0]};
        we    = in_range_q;
      end
      ACT_RESUME: begin
        wdata = {1'b1, rd_cnt[TimerW-2:0]};
        we    = in_range_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (state_q != ST_EXEC) begin
      we = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    idx_d       = idx_q;
    dur_d       = dur_q;
    in_range_d  = in_range_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d      = in_data_i.action;
          idx_d      = in_data_i.timer_index;
          dur_d      = in_data_i.duration_ticks;
          in_range_d = ({1'b0, in_data_i.timer_index} < (IndexW + 1)'(NUM_TIMERS));
          sweep_d    = '0;
          if (in_data_i.action <= ACT_QUERY) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          if (is_query) begin
            out_valid_d                = 1'b1;
            out_data_d.queried_index   = idx_q;
            out_data_d.expired         = !rd_cnt[TimerW-1];
            out_data_d.running         = rd_cnt[TimerW-1];
          end
          if (is_tick && !sweep_last) begin
            sweep_d = sweep_q + AddrW'(1);
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      sweep_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sweep_q     <= sweep_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    idx_q      <= idx_d;
    dur_q      <= dur_d;
    in_range_q <= in_range_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q  <= mem_q[raddr];
      rd_vld_q <= vld_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (sweep_q <= AddrW'(NUM_TIMERS - 1)))
    else $error("tick sweep index out of range");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EXEC && act_q == ACT_QUERY))
    else $error("result beat raised without a query");

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.action == ACT_QUERY && !out_valid_o) |-> ##3 out_valid_o)
    else $error("query result late");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && !is_tick) |-> in_range_q)
    else $error("counter write for an index outside the bank");

endmodule

`default_nettype wire
